[sv/assert_macros.svh]
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/jsu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package jsu_pkg;

  // Decoder mode, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_STR  = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNTERM     = 3'd1,
    ERR_EOT_ESC    = 3'd2,
    ERR_BAD_HEX    = 3'd3,
    ERR_UNKNOWN    = 3'd4
  } err_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_U = 8'h75;

  // Results caused by one input byte: up to three, all of one kind.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    kind_t           kind;
    err_t            err;
  } result_t;

  // Returns {valid, value} for one ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/jsu_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module jsu_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_eot,
  output jsu_pkg::result_t       res
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     hc_r, hc_nxt;
  logic [15:0]    cp_r, cp_nxt;
  logic [4:0]     dig;
  logic [15:0]    cp_full;

  always_comb begin
    res      = '0;
    res.kind = jsu_pkg::KIND_DATA;
    res.err  = jsu_pkg::ERR_NONE;
    mode_nxt = mode_r;
    hc_nxt   = hc_r;
    cp_nxt   = cp_r;
    dig      = jsu_pkg::hex_digit(in_byte);
    cp_full  = {cp_r[11:0], dig[3:0]};
    case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (!in_eot) mode_nxt = jsu_pkg::MODE_STR;
      end
      jsu_pkg::MODE_STR: begin
        if (in_eot) begin
          res.cnt = 2'd1; res.kind = jsu_pkg::KIND_ERROR; res.err = jsu_pkg::ERR_UNTERM;
          mode_nxt = jsu_pkg::MODE_IDLE; hc_nxt = '0; cp_nxt = '0;
        end else if (in_byte == jsu_pkg::CH_QUOTE) begin
          res.cnt = 2'd1; res.kind = jsu_pkg::KIND_CLOSE;
          mode_nxt = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end else begin
          res.cnt = 2'd1; res.bytes[0] = in_byte;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_eot) begin
          res.cnt = 2'd1; res.kind = jsu_pkg::KIND_ERROR; res.err = jsu_pkg::ERR_EOT_ESC;
          mode_nxt = jsu_pkg::MODE_IDLE; hc_nxt = '0; cp_nxt = '0;
        end else begin
          mode_nxt = jsu_pkg::MODE_STR;
          res.cnt  = 2'd1;
          case (in_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: res.bytes[0] = in_byte;
            jsu_pkg::CH_N: res.bytes[0] = 8'h0A;
            jsu_pkg::CH_R: res.bytes[0] = 8'h0D;
            jsu_pkg::CH_T: res.bytes[0] = 8'h09;
            jsu_pkg::CH_B: res.bytes[0] = 8'h08;
            jsu_pkg::CH_F: res.bytes[0] = 8'h0C;
            jsu_pkg::CH_U: begin
              res.cnt  = 2'd0;
              mode_nxt = jsu_pkg::MODE_HEX; hc_nxt = '0; cp_nxt = '0;
            end
            default: begin
              res.kind = jsu_pkg::KIND_ERROR; res.err = jsu_pkg::ERR_UNKNOWN;
              mode_nxt = jsu_pkg::MODE_IDLE; hc_nxt = '0; cp_nxt = '0;
            end
          endcase
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (in_eot || !dig[4]) begin
          res.cnt = 2'd1; res.kind = jsu_pkg::KIND_ERROR; res.err = jsu_pkg::ERR_BAD_HEX;
          mode_nxt = jsu_pkg::MODE_IDLE; hc_nxt = '0; cp_nxt = '0;
        end else if (hc_r != 2'd3) begin
          cp_nxt = cp_full;
          hc_nxt = hc_r + 2'd1;
        end else begin
          mode_nxt = jsu_pkg::MODE_STR; hc_nxt = '0; cp_nxt = '0;
          if (cp_full[15:7] == 9'd0) begin
            res.cnt = 2'd1;
            res.bytes[0] = cp_full[7:0];
          end else if (cp_full[15:11] == 5'd0) begin
            res.cnt = 2'd2;
            res.bytes[0] = {3'b110, cp_full[10:6]};
            res.bytes[1] = {2'b10, cp_full[5:0]};
          end else begin
            res.cnt = 2'd3;
            res.bytes[0] = {4'b1110, cp_full[15:12]};
            res.bytes[1] = {2'b10, cp_full[11:6]};
            res.bytes[2] = {2'b10, cp_full[5:0]};
          end
        end
      end
      default: begin
        mode_nxt = jsu_pkg::MODE_IDLE; hc_nxt = '0; cp_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_IDLE;
      hc_r   <= '0;
      cp_r   <= '0;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      hc_r   <= hc_nxt;
      cp_r   <= cp_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/jsu_outbuf.sv]
`timescale 1ns / 1ps
`default_nettype none
module jsu_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire jsu_pkg::result_t  res,
  output logic                   can_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic [1:0]             out_kind,
  output logic [2:0]             out_error_code,
  output logic                   out_last
);

  logic [1:0]      cnt_r, cnt_nxt;
  logic [2:0][7:0] bytes_r, bytes_nxt;
  jsu_pkg::kind_t  kind_r, kind_nxt;
  jsu_pkg::err_t   err_r, err_nxt;
  logic            take;

  assign out_valid      = (cnt_r != 2'd0);
  assign out_byte       = bytes_r[0];
  assign out_kind       = kind_r;
  assign out_error_code = err_r;
  assign out_last       = (cnt_r == 2'd1);
  assign take           = out_valid && out_ready;
  // A new bundle may enter when the register is empty or its last byte leaves now.
  assign can_take       = !out_valid || (take && out_last);

  always_comb begin
    cnt_nxt   = cnt_r;
    bytes_nxt = bytes_r;
    kind_nxt  = kind_r;
    err_nxt   = err_r;
    if (in_acc) begin
      cnt_nxt   = res.cnt;
      bytes_nxt = res.bytes;
      kind_nxt  = res.kind;
      err_nxt   = res.err;
    end else if (take) begin
      cnt_nxt   = cnt_r - 2'd1;
      bytes_nxt = {8'h00, bytes_r[2], bytes_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    kind_r  <= kind_nxt;
    err_r   <= err_nxt;
  end

endmodule
`default_nettype wire

[sv/json_string_unescape.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Ports
// -------  ---------  --------------------------------------------------------
// in       input      in_valid, in_ready, in_byte, in_end_of_text
// out      output     out_valid, out_ready, out_byte, out_kind, out_error_code,
//                     out_last
//
// While out_ready is high, one input transaction is taken per cycle while each byte
// yields at most one result, and a \u escape that closes with a two- or three-byte
// UTF-8 sequence holds in_ready low while the result register drains one byte per
// cycle. Results appear in the cycle after the input transaction that causes them.
// rst_n is synchronous and active low; it returns the decoder to idle and empties
// the result register. A stall on out_ready backs up to in_ready in the same cycle.

`include "assert_macros.svh"

module json_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      out_kind,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  // The decoder sees each byte as it arrives and commits its mode, digit count and
  // partial code point only when the transaction is taken. Its whole answer for the
  // byte (up to three result bytes, or a close or error marker) is loaded in one go
  // into the result register, which then hands the bytes out one per transaction.
  jsu_pkg::result_t res;
  logic             in_acc;
  logic             can_take;

  assign in_ready = can_take;
  assign in_acc   = in_valid && in_ready;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_byte (in_byte),
    .in_eot  (in_end_of_text),
    .res     (res)
  );

  jsu_outbuf u_outbuf (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_acc         (in_acc),
    .res            (res),
    .can_take       (can_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  // A close or error marker is always the only, and so the final, result of its byte.
  `ASSERT_CLK(a_marker_last, clk, rst_n, out_valid && (out_kind != jsu_pkg::KIND_DATA) |-> out_last, "close or error result without last")
  // Input is only accepted when the result register is empty or its last byte leaves now.
  `ASSERT_CLK(a_ready_drain, clk, rst_n, in_ready |-> (!out_valid || (out_ready && out_last)), "input taken while results still pending")
  // Data bytes never carry an error code.
  `ASSERT_CLK(a_data_no_err, clk, rst_n, out_valid && (out_kind == jsu_pkg::KIND_DATA) |-> (out_error_code == jsu_pkg::ERR_NONE), "data byte with error code")
  // Reset leaves the result register empty.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !$past(rst_n) |-> !out_valid, "results present after reset")

endmodule
`default_nettype wire

[tb/sv/json_unescape_checker.sv]
`timescale 1ns / 1ps

module json_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_kind,
  input  logic [2:0] out_error_code,
  input  logic       out_last,
  output int         error_count,
  output int         outstanding
);

  typedef struct packed {
    logic [7:0]     data;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  err;
    logic           last;
  } unesc_result_t;

  unesc_result_t awaited_results[$];
  unesc_result_t got;
  unesc_result_t want;

  // Decoder state as the block should hold it.
  jsu_pkg::mode_t dec_mode;
  logic [1:0]     digits_seen;
  logic [15:0]    code_acc;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic unesc_result_t data_result(input logic [7:0] b);
    return unesc_result_t'{b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 1'b0};
  endfunction

  // Works out the results of one input transaction and queues them.
  task automatic unescape_step(input logic [7:0] c, input logic eot);
    unesc_result_t step_q[$];
    jsu_pkg::err_t fault;
    logic [7:0]    mapped;
    logic          known;
    logic [15:0]   cp;
    int            nib;
    fault  = jsu_pkg::ERR_NONE;
    mapped = 8'h00;
    known  = 1'b1;
    case (dec_mode)
      jsu_pkg::MODE_IDLE: begin
        if (!eot) dec_mode = jsu_pkg::MODE_STR;
      end
      jsu_pkg::MODE_STR: begin
        if (eot) begin
          fault = jsu_pkg::ERR_UNTERM;
        end else if (c == jsu_pkg::CH_QUOTE) begin
          dec_mode = jsu_pkg::MODE_IDLE;
          step_q.insert(step_q.size(),
                        unesc_result_t'{8'h00, jsu_pkg::KIND_CLOSE, jsu_pkg::ERR_NONE, 1'b0});
        end else if (c == jsu_pkg::CH_BSLASH) begin
          dec_mode = jsu_pkg::MODE_ESC;
        end else begin
          step_q.insert(step_q.size(), data_result(c));
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (eot) begin
          fault = jsu_pkg::ERR_EOT_ESC;
        end else if (c == jsu_pkg::CH_U) begin
          dec_mode    = jsu_pkg::MODE_HEX;
          digits_seen = 2'd0;
          code_acc    = 16'h0000;
        end else begin
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: mapped = c;
            jsu_pkg::CH_N: mapped = 8'h0A;
            jsu_pkg::CH_R: mapped = 8'h0D;
            jsu_pkg::CH_T: mapped = 8'h09;
            jsu_pkg::CH_B: mapped = 8'h08;
            jsu_pkg::CH_F: mapped = 8'h0C;
            default: known = 1'b0;
          endcase
          if (known) begin
            dec_mode = jsu_pkg::MODE_STR;
            step_q.insert(step_q.size(), data_result(mapped));
          end else begin
            fault = jsu_pkg::ERR_UNKNOWN;
          end
        end
      end
      default: begin
        nib = eot ? -1 : hex_nibble(c);
        if (nib < 0) begin
          fault = jsu_pkg::ERR_BAD_HEX;
        end else begin
          cp = {code_acc[11:0], nib[3:0]};
          if (digits_seen != 2'd3) begin
            code_acc    = cp;
            digits_seen = digits_seen + 2'd1;
          end else begin
            dec_mode    = jsu_pkg::MODE_STR;
            digits_seen = 2'd0;
            code_acc    = 16'h0000;
            // Each half of a surrogate pair is encoded on its own.
            if (cp < 16'h0080) begin
              step_q.insert(step_q.size(), data_result(cp[7:0]));
            end else if (cp < 16'h0800) begin
              step_q.insert(step_q.size(), data_result({3'b110, cp[10:6]}));
              step_q.insert(step_q.size(), data_result({2'b10, cp[5:0]}));
            end else begin
              step_q.insert(step_q.size(), data_result({4'b1110, cp[15:12]}));
              step_q.insert(step_q.size(), data_result({2'b10, cp[11:6]}));
              step_q.insert(step_q.size(), data_result({2'b10, cp[5:0]}));
            end
          end
        end
      end
    endcase
    if (fault != jsu_pkg::ERR_NONE) begin
      dec_mode    = jsu_pkg::MODE_IDLE;
      digits_seen = 2'd0;
      code_acc    = 16'h0000;
      step_q.insert(step_q.size(),
                    unesc_result_t'{8'h00, jsu_pkg::KIND_ERROR, fault, 1'b0});
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) awaited_results.insert(awaited_results.size(), step_q[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dec_mode    = jsu_pkg::MODE_IDLE;
      digits_seen = 2'd0;
      code_acc    = 16'h0000;
      awaited_results.delete();
      error_count = 0;
    end else begin
      if (in_valid && in_ready) unescape_step(in_byte, in_end_of_text);
      if (out_valid && out_ready) begin
        got = unesc_result_t'{out_byte, jsu_pkg::kind_t'(out_kind),
                              jsu_pkg::err_t'(out_error_code), out_last};
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: byte %h kind %0d err %0d last %0b",
                   $time, got.data, got.kind, got.err, got.last);
          error_count = error_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected byte %h kind %0d err %0d last %0b,",
                     $time, want.data, want.kind, want.err, want.last,
                     " got byte %h kind %0d err %0d last %0b",
                     got.data, got.kind, got.err, got.last);
            error_count = error_count + 1;
          end
        end
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

[tb/sv/json_string_unescape_tb.sv]
`timescale 1ns / 1ps

module json_string_unescape_tb;

  // Cycles without any transaction on either channel before the run is abandoned.
  // Stalls are random at roughly one in three, so a genuine run never comes close.
  localparam int STALL_LIMIT = 1000;
  // Random stimulus stops once about this many input transactions have been sent
  // after the directed part, which itself sends a little under thirty.
  localparam int RANDOM_ITEMS = 140;

  typedef struct {
    logic [7:0] b;
    logic       eot;
  } text_item_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  int error_count;
  int outstanding;
  int idle_cycles = 0;
  int sent_count  = 0;
  // While set, neither side inserts bubbles, so the block runs flat out.
  logic calm = 1'b0;

  text_item_t text_q[$];

  localparam logic [7:0] ESC_LETTERS [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                             jsu_pkg::CH_SLASH, jsu_pkg::CH_N,
                                             jsu_pkg::CH_R, jsu_pkg::CH_T,
                                             jsu_pkg::CH_B, jsu_pkg::CH_F};

  json_string_unescape i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  json_unescape_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last),
    .error_count    (error_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls about 36 percent of the time, except during the calm stretch.
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 36);
    end
  end

  // Watchdog: counts cycles in which no transaction completes on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("json_string_unescape_tb: done, errors");
      $finish;
    end
  end

  // Offers one item on the input channel and returns at the falling edge after it has
  // been taken. Bubbles of random length come first unless the calm stretch is on.
  // The payload is only touched at falling edges, and valid stays up until the
  // transaction completes.
  task automatic drive_item(input logic [7:0] b, input logic eot);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid       <= 1'b0;
      in_byte        <= 8'($urandom);
      in_end_of_text <= 1'($urandom);
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) drive_item(text_q[i].b, text_q[i].eot);
    text_q.delete();
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), text_item_t'{b, 1'b0});
  endfunction

  // End of text carries no byte, so the byte lane holds junk to show it is ignored.
  function automatic void add_end();
    text_q.insert(text_q.size(), text_item_t'{8'($urandom), 1'b1});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    // Letters come in either case at random.
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
           || (c >= 8'h61 && c <= 8'h66);
  endfunction

  // A \u escape whose code point falls in the one-, two- or three-byte UTF-8 range.
  function automatic void add_unicode();
    logic [15:0] cp;
    case ($urandom_range(2))
      0:       cp = 16'($urandom_range(16'h007F));
      1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
      default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
    endcase
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(hex_char(cp[15:12]));
    add_byte(hex_char(cp[11:8]));
    add_byte(hex_char(cp[7:4]));
    add_byte(hex_char(cp[3:0]));
  endfunction

  // One well-formed piece of string content: a plain byte, a short escape or \u.
  function automatic void add_content();
    logic [7:0] b;
    case ($urandom_range(3))
      0, 1: begin
        do b = 8'($urandom); while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        add_byte(b);
      end
      2: begin
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(ESC_LETTERS[$urandom_range(7)]);
      end
      default: add_unicode();
    endcase
  endfunction

  // A string that goes wrong: cut off by end of text in any state, a bad hex digit
  // part-way through \u, or an escape letter the decoder does not know.
  function automatic void add_broken_tail();
    logic [7:0] b;
    int         digits;
    digits = $urandom_range(3);
    case ($urandom_range(4))
      0: add_end();
      1: begin
        add_byte(jsu_pkg::CH_BSLASH);
        add_end();
      end
      2, 3: begin
        add_byte(jsu_pkg::CH_BSLASH);
        add_byte(jsu_pkg::CH_U);
        repeat (digits) add_byte(hex_char(4'($urandom)));
        if ($urandom_range(1)) begin
          add_end();
        end else begin
          do b = 8'($urandom); while (is_hex_char(b));
          add_byte(b);
        end
      end
      default: begin
        add_byte(jsu_pkg::CH_BSLASH);
        do b = 8'($urandom);
        while (b == jsu_pkg::CH_U || b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH
               || b == jsu_pkg::CH_SLASH || b == jsu_pkg::CH_N || b == jsu_pkg::CH_R
               || b == jsu_pkg::CH_T || b == jsu_pkg::CH_B || b == jsu_pkg::CH_F);
        add_byte(b);
      end
    endcase
  endfunction

  initial begin
    int n_parts;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_byte        = 8'h00;
    in_end_of_text = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. End of text while idle is ignored, and any byte opens a string,
    // here an 'x'. Then the byte extremes pass through, and \u0000 gives a zero byte.
    add_end();
    add_byte(8'h78);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    repeat (4) add_byte(8'h30);
    // Text ends inside the string: unterminated.
    add_end();
    // Text ends straight after a backslash.
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_end();
    // Text ends among the hex digits of \u.
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(8'h41);
    add_end();
    // Unknown escape letter 'q'.
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(8'h71);
    // A non-hex 'g' where a hex digit belongs.
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_BSLASH);
    add_byte(jsu_pkg::CH_U);
    add_byte(8'h67);
    // An empty string, closed properly.
    add_byte(jsu_pkg::CH_QUOTE);
    add_byte(jsu_pkg::CH_QUOTE);
    send_text();

    // Random part: mostly well-formed strings with random content, the rest broken
    // strings, odd opening bytes and stray end-of-text marks while idle. A stretch in
    // the middle runs with no bubbles on either side.
    while (sent_count < RANDOM_ITEMS) begin
      calm <= (sent_count >= 40 && sent_count < 90);
      if ($urandom_range(9) == 0) begin
        // Ignored by the block, so not counted.
        add_end();
        send_text();
      end
      if ($urandom_range(9) == 0) begin
        add_byte(8'($urandom));
      end else begin
        add_byte(jsu_pkg::CH_QUOTE);
      end
      n_parts = $urandom_range(6);
      repeat (n_parts) add_content();
      if ($urandom_range(99) < 80) begin
        add_byte(jsu_pkg::CH_QUOTE);
      end else begin
        add_broken_tail();
      end
      sent_count += text_q.size();
      send_text();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // Every string ends in a close or an error, so once the last result has been
    // taken the block has nothing in hand; waiting on afterwards catches stray results.
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("json_string_unescape_tb: done, clean");
    end else begin
      $display("json_string_unescape_tb: done, errors");
    end
    $finish;
  end

endmodule
